// ===== rtl/frpr_pkg.sv =====
// Package for the filtered packet receive ring.
// Holds codes, defaults and the controller/datapath interface structs.
// No dependencies.
package frpr_pkg;

  // Default geometry of the ring.
  localparam int SLOTS_DEF        = 8;
  localparam int PACKET_BYTES_DEF = 32;

  // Field widths.
  localparam int ACT_W  = 2;
  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Input item actions.
  localparam logic [ACT_W-1:0] ACT_RX    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILTERED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READY    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONITOR  = 1'd1;

  // Byte offsets inside a packet and the wildcard frame type.
  localparam int ID_BYTE   = 4;
  localparam int TYPE_BYTE = 0;
  localparam logic [BYTE_W-1:0] ANY_TYPE = 8'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic clr_step;   // write one zero entry of the clearing pass
    logic rd_id;      // read the id byte of the write slot
    logic fin_rx;     // judge the finished packet and post its result
    logic pop_rd;     // read the first byte of the head packet
    logic pop_out;    // post one popped byte and read the next
    logic empty_out;  // post the ring-empty result
    logic rd_type;    // read the type byte of the head packet
    logic q_out;      // post the ready answer
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic ring_empty;
    logic pop_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/frpr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module frpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/frpr_ctrl.sv =====
// Controller for the filtered packet receive ring.
// Sequences clearing, receive, pop and query; depends on frpr_pkg.
module frpr_ctrl
  import frpr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ACT_W-1:0] action_i,
  input  logic             rx_last_i,
  input  stat_t            stat_i,
  output cmd_t             cmd_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_RX_RD   = 3'd2;
  localparam logic [2:0] S_RX_FIN  = 3'd3;
  localparam logic [2:0] S_POP_RD  = 3'd4;
  localparam logic [2:0] S_POP_OUT = 3'd5;
  localparam logic [2:0] S_EMPTY   = 3'd6;
  localparam logic [2:0] S_Q_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  // Items are taken only while idle.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_RX: begin
              if (rx_last_i) begin
                state_d = S_RX_RD;
              end
            end
            ACT_POP: begin
              state_d = stat_i.ring_empty ? S_EMPTY : S_POP_RD;
            end
            ACT_QUERY: begin
              cmd_o.rd_type = 1'b1;
              state_d = S_Q_OUT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RX_RD: begin
        cmd_o.rd_id = 1'b1;
        state_d = S_RX_FIN;
      end
      S_RX_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin_rx = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.pop_out = 1'b1;
          if (stat_i.pop_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.empty_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_Q_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.q_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is posted only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.fin_rx || cmd_o.pop_out || cmd_o.empty_out || cmd_o.q_out) |-> stat_i.out_free)
    else $error("result posted while output register busy");

  // A final pop byte always returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop_out && stat_i.pop_last) |=> (state_q == S_IDLE))
    else $error("pop did not end after final byte");

  // The clearing pass hands over to idle and never comes back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass reentered");

endmodule

// ===== rtl/frpr_datapath.sv =====
// Datapath for the filtered packet receive ring: packet store, ring pointers,
// counters, configuration and the output register. Depends on frpr_pkg, frpr_ram.
module frpr_datapath
  import frpr_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  logic [BYTE_W-1:0]     query_type_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     result_kind_o,
  output logic [BYTE_W-1:0]     data_byte_o,
  output logic                  run_last_o,
  output logic                  ready_flag_o,
  output logic [CNT_W-1:0]      received_total_o,
  output logic [CNT_W-1:0]      lost_total_o
);

  localparam int DEPTH = SLOTS * PACKET_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SLOTS);
  localparam int PW    = $clog2(PACKET_BYTES + 1);
  localparam int IW    = $clog2(PACKET_BYTES);

  // Ring state.
  logic [SW-1:0]     wslot_q, rslot_q;
  logic [PW-1:0]     pos_q;
  logic              full_q, empty_q;
  logic [CNT_W-1:0]  pkt_cnt_q, lost_cnt_q;
  logic [IW-1:0]     idx_q;
  logic [AW-1:0]     clr_cnt_q;
  logic [BYTE_W-1:0] local_id_q;
  logic              monitor_q;
  logic [BYTE_W-1:0] qtype_q;

  // Output register.
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [BYTE_W-1:0] data_q;
  logic              last_q;
  logic              ready_q;

  logic              out_free;
  logic              load;
  logic [SW-1:0]     wslot_nx, rslot_nx;
  logic [AW-1:0]     wbase, rbase;
  logic              pos_room;
  logic              pop_last;
  logic              filtered;

  // RAM ports.
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = cmd_i.fin_rx || cmd_i.pop_out || cmd_i.empty_out || cmd_i.q_out;

  assign wslot_nx = (wslot_q == SW'(SLOTS - 1)) ? '0 : wslot_q + 1'b1;
  assign rslot_nx = (rslot_q == SW'(SLOTS - 1)) ? '0 : rslot_q + 1'b1;
  assign wbase    = AW'(wslot_q) * AW'(PACKET_BYTES);
  assign rbase    = AW'(rslot_q) * AW'(PACKET_BYTES);
  assign pos_room = (pos_q < PW'(PACKET_BYTES));
  assign pop_last = (idx_q == IW'(PACKET_BYTES - 1));
  assign filtered = !monitor_q && (ram_rdata != local_id_q);

  assign stat_o.clr_done   = (clr_cnt_q == AW'(DEPTH - 1));
  assign stat_o.ring_empty = empty_q;
  assign stat_o.pop_last   = pop_last;
  assign stat_o.out_free   = out_free;

  // Write port: the clearing pass, or a received byte with room in a free ring.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wbase + AW'(pos_q);
    ram_wdata = rx_byte_i;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.accept && (action_i == ACT_RX) && pos_room && !full_q) begin
      ram_we = 1'b1;
    end
  end

  // Read port: id byte, type byte, or the next byte of a pop.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rbase + AW'(TYPE_BYTE);
    if (cmd_i.rd_id) begin
      ram_re    = 1'b1;
      ram_raddr = wbase + AW'(ID_BYTE);
    end else if (cmd_i.pop_rd) begin
      ram_re    = 1'b1;
      ram_raddr = rbase;
    end else if (cmd_i.pop_out && !pop_last) begin
      ram_re    = 1'b1;
      ram_raddr = rbase + AW'(idx_q) + AW'(1);
    end else if (cmd_i.rd_type) begin
      ram_re    = 1'b1;
      ram_raddr = rbase + AW'(TYPE_BYTE);
    end
  end

  frpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= '0;
      monitor_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCAL_ID: local_id_q <= cfg_data_i;
        REG_MONITOR:  monitor_q  <= cfg_data_i[0];
        default: begin
          local_id_q <= local_id_q;
        end
      endcase
    end
  end

  // Query type is held from acceptance until the answer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      qtype_q <= query_type_i;
    end
  end

  // Clearing pass address counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step && !stat_o.clr_done) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Byte position within the packet being received.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.fin_rx) begin
      pos_q <= '0;
    end else if (cmd_i.accept && (action_i == ACT_RX) && pos_room) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  // Pop byte index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.pop_rd) begin
      idx_q <= '0;
    end else if (cmd_i.pop_out && !pop_last) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Ring pointers, flags and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q    <= '0;
      rslot_q    <= '0;
      full_q     <= 1'b0;
      empty_q    <= 1'b1;
      pkt_cnt_q  <= '0;
      lost_cnt_q <= '0;
    end else begin
      if (cmd_i.fin_rx) begin
        pkt_cnt_q <= pkt_cnt_q + 1'b1;
        if (!filtered) begin
          if (full_q) begin
            lost_cnt_q <= lost_cnt_q + 1'b1;
          end else begin
            wslot_q <= wslot_nx;
            full_q  <= (wslot_nx == rslot_q);
            empty_q <= 1'b0;
          end
        end
      end
      if (cmd_i.pop_out && pop_last) begin
        rslot_q <= rslot_nx;
        empty_q <= (rslot_nx == wslot_q);
        full_q  <= 1'b0;
      end
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q  <= '0;
      last_q  <= 1'b1;
      ready_q <= 1'b0;
      if (cmd_i.fin_rx) begin
        kind_q <= filtered ? KIND_FILTERED : (full_q ? KIND_DROPPED : KIND_STORED);
      end else if (cmd_i.pop_out) begin
        kind_q <= KIND_DATA;
        data_q <= ram_rdata;
        last_q <= pop_last;
      end else if (cmd_i.q_out) begin
        kind_q  <= KIND_READY;
        ready_q <= !empty_q && ((qtype_q == ANY_TYPE) || (ram_rdata == qtype_q));
      end else begin
        kind_q <= KIND_EMPTY;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign data_byte_o      = data_q;
  assign run_last_o       = last_q;
  assign ready_flag_o     = ready_q;
  assign received_total_o = pkt_cnt_q;
  assign lost_total_o     = lost_cnt_q;

  // The ring is never full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_q && empty_q))
    else $error("ring full and empty together");

  // Full or empty only when the two slots meet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q || empty_q) |-> (wslot_q == rslot_q))
    else $error("ring flag set with slots apart");

  // A dropped packet raises the lost count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin_rx && !filtered && full_q) |=> (lost_cnt_q == $past(lost_cnt_q) + 1'b1))
    else $error("dropped packet not counted");

endmodule

// ===== rtl/filtered_packet_receive_ring_core.sv =====
// Top level of the filtered packet receive ring.
// Depends on frpr_pkg, frpr_ctrl, frpr_datapath (which holds frpr_ram).
//
// The input channel carries one item per handshake: a received byte, a pop
// of the head packet, or a ready query. The output channel carries results.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. Configuration (station id, monitor mode) is written through
// a plain write port, by the user only while the block is idle; unenforced.
// After reset the packet store is cleared, one entry a cycle, through all
// SLOTS * PACKET_BYTES entries (256 at the default size); no item is taken
// during that time.
// A non-final received byte gives no result. For a final byte the item is
// accepted, the store is read through its single registered read port, and
// the result is loaded into the output register. For a query the store is
// read in the cycle the item is accepted, and the answer is loaded once the
// output register is free. A pop reads its first byte in a read state and
// then posts one byte a cycle while the output register is free; a pop from
// an empty ring posts the ring-empty result. A new item may be accepted while
// the last result still waits in the output register. A stalled receiver
// holds the result and the block waits before posting the next one.
module filtered_packet_receive_ring_core
  import frpr_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  logic                  rx_last_i,
  input  logic [BYTE_W-1:0]     query_type_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     result_kind_o,
  output logic [BYTE_W-1:0]     data_byte_o,
  output logic                  run_last_o,
  output logic                  ready_flag_o,
  output logic [CNT_W-1:0]      received_total_o,
  output logic [CNT_W-1:0]      lost_total_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  frpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .rx_last_i  (rx_last_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Store, pointers, counters and output register.
  frpr_datapath #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .rx_byte_i        (rx_byte_i),
    .query_type_i     (query_type_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .data_byte_o      (data_byte_o),
    .run_last_o       (run_last_o),
    .ready_flag_o     (ready_flag_o),
    .received_total_o (received_total_o),
    .lost_total_o     (lost_total_o)
  );

endmodule

// ===== test/ring_checker.sv =====
// Checker for the filtered packet receive ring testbench.
// Watches the item, result and register ports beside the block, predicts each
// item's results and compares them in order. Depends on frpr_pkg.
`timescale 1ns / 100ps

module ring_checker
  import frpr_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  logic                  rx_last_i,
  input  logic [BYTE_W-1:0]     query_type_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [KIND_W-1:0]     result_kind_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  run_last_i,
  input  logic                  ready_flag_i,
  input  logic [CNT_W-1:0]      received_total_i,
  input  logic [CNT_W-1:0]      lost_total_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ready;
    logic [CNT_W-1:0]  received;
    logic [CNT_W-1:0]  lost;
  } ring_result_t;

  // Shadow copy of the ring, its counters and its registers.
  logic [BYTE_W-1:0] slot_bytes [SLOTS*PACKET_BYTES];
  int unsigned       wr_slot;
  int unsigned       rd_slot;
  int unsigned       fill_pos;
  logic              ring_full;
  logic              ring_empty;
  logic [CNT_W-1:0]  seen_pkts;
  logic [CNT_W-1:0]  lost_pkts;
  logic [BYTE_W-1:0] station_id;
  logic              monitor_on;

  ring_result_t due_results [$];
  ring_result_t want_res;
  int           mismatches;

  function automatic int unsigned slot_after(int unsigned slot);
    return (slot + 1 >= SLOTS) ? 0 : slot + 1;
  endfunction

  function automatic void post_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                      logic last, logic ready);
    ring_result_t res;
    res.kind     = kind;
    res.data     = data;
    res.last     = last;
    res.ready    = ready;
    res.received = seen_pkts;
    res.lost     = lost_pkts;
    due_results.push_back(res);
  endfunction

  // Update the shadow ring for one item and queue the results it causes.
  function automatic void apply_item(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data,
                                     logic last, logic [BYTE_W-1:0] qtype);
    int unsigned       wbase;
    int unsigned       rbase;
    logic [KIND_W-1:0] kind;
    logic              hit;
    wbase = wr_slot * PACKET_BYTES;
    rbase = rd_slot * PACKET_BYTES;
    case (act)
      ACT_RX: begin
        // Bytes past the slot are dropped; a full ring keeps the old contents.
        if (fill_pos < PACKET_BYTES) begin
          if (!ring_full) slot_bytes[wbase + fill_pos] = data;
          fill_pos++;
        end
        if (last) begin
          fill_pos = 0;
          seen_pkts++;
          // The address test reads the write slot as it stands, before the full test.
          if (!monitor_on && slot_bytes[wbase + ID_BYTE] != station_id) begin
            kind = KIND_FILTERED;
          end else if (ring_full) begin
            lost_pkts++;
            kind = KIND_DROPPED;
          end else begin
            wr_slot = slot_after(wr_slot);
            if (wr_slot == rd_slot) ring_full = 1'b1;
            ring_empty = 1'b0;
            kind = KIND_STORED;
          end
          post_result(kind, '0, 1'b1, 1'b0);
        end
      end
      ACT_POP: begin
        if (ring_empty) begin
          post_result(KIND_EMPTY, '0, 1'b1, 1'b0);
        end else begin
          for (int i = 0; i < PACKET_BYTES; i++)
            post_result(KIND_DATA, slot_bytes[rbase + i], i == PACKET_BYTES - 1, 1'b0);
          rd_slot = slot_after(rd_slot);
          if (rd_slot == wr_slot) ring_empty = 1'b1;
          ring_full = 1'b0;
        end
      end
      ACT_QUERY: begin
        hit = !ring_empty &&
              (qtype == ANY_TYPE || slot_bytes[rbase + TYPE_BYTE] == qtype);
        post_result(KIND_READY, '0, 1'b1, hit);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Register writes, result checks, then prediction of the accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_bytes[i]) slot_bytes[i] = '0;
      wr_slot    = 0;
      rd_slot    = 0;
      fill_pos   = 0;
      ring_full  = 1'b0;
      ring_empty = 1'b1;
      seen_pkts  = '0;
      lost_pkts  = '0;
      station_id = '0;
      monitor_on = 1'b0;
      mismatches = 0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LOCAL_ID) station_id = cfg_data_i;
        else if (cfg_idx_i == REG_MONITOR) monitor_on = cfg_data_i[0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result of kind %0d arrived with none expected", result_kind_i);
          mismatches++;
        end else begin
          want_res = due_results.pop_front();
          check_field("result_kind", CNT_W'(want_res.kind), CNT_W'(result_kind_i));
          check_field("data_byte", CNT_W'(want_res.data), CNT_W'(data_byte_i));
          check_field("run_last", CNT_W'(want_res.last), CNT_W'(run_last_i));
          check_field("ready_flag", CNT_W'(want_res.ready), CNT_W'(ready_flag_i));
          check_field("received_total", want_res.received, received_total_i);
          check_field("lost_total", want_res.lost, lost_total_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        apply_item(action_i, rx_byte_i, rx_last_i, query_type_i);
    end
    errors_o  = mismatches;
    pending_o = due_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the filtered packet receive ring testbench.
// Drives items, register writes and receiver stalls into the block; the ring_checker
// beside it predicts and compares. Depends on frpr_pkg, ring_checker and the ring core.
`timescale 1ns / 100ps

module testbench;
  import frpr_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  localparam int PACKET_BYTES   = PACKET_BYTES_DEF;
  localparam int SETTLE_CYCLES  = PACKET_BYTES + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_HOLD} flow_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ACT_W-1:0]      action_i;
  logic [BYTE_W-1:0]     rx_byte_i;
  logic                  rx_last_i;
  logic [BYTE_W-1:0]     query_type_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [KIND_W-1:0]     result_kind_o;
  logic [BYTE_W-1:0]     data_byte_o;
  logic                  run_last_o;
  logic                  ready_flag_o;
  logic [CNT_W-1:0]      received_total_o;
  logic [CNT_W-1:0]      lost_total_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int items_sent;
  int burst_left;
  bit hold_req;

  filtered_packet_receive_ring_core #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .rx_byte_i        (rx_byte_i),
    .rx_last_i        (rx_last_i),
    .query_type_i     (query_type_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .data_byte_o      (data_byte_o),
    .run_last_o       (run_last_o),
    .ready_flag_o     (ready_flag_o),
    .received_total_o (received_total_o),
    .lost_total_o     (lost_total_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  ring_checker #(
    .SLOTS        (SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .rx_byte_i        (rx_byte_i),
    .rx_last_i        (rx_last_i),
    .query_type_i     (query_type_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_i    (result_kind_o),
    .data_byte_i      (data_byte_o),
    .run_last_i       (run_last_o),
    .ready_flag_i     (ready_flag_o),
    .received_total_i (received_total_o),
    .lost_total_i     (lost_total_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .errors_o         (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one item, in bursts with random gaps, and wait until it is taken.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data,
                           input logic last, input logic [BYTE_W-1:0] qtype);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    rx_byte_i    <= data;
    rx_last_i    <= last;
    query_type_i <= qtype;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    if (act != ACT_NONE) items_sent++;
  endtask

  task automatic send_rx(input logic [BYTE_W-1:0] data, input logic last);
    send_item(ACT_RX, data, last, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic pop_head();
    send_item(ACT_POP, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic ask_ready(input logic [BYTE_W-1:0] qtype);
    send_item(ACT_QUERY, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), qtype);
  endtask

  // A packet with the given frame type and station byte; the rest is random.
  task automatic send_packet(input int len, input logic [BYTE_W-1:0] frame_type,
                             input logic [BYTE_W-1:0] id_byte);
    logic [BYTE_W-1:0] data;
    for (int i = 0; i < len; i++) begin
      if (i == TYPE_BYTE) data = frame_type;
      else if (i == ID_BYTE) data = id_byte;
      else data = BYTE_W'($urandom_range(0, 255));
      send_rx(data, i == len - 1);
    end
  endtask

  // Both registers are written back to back while no item is in flight.
  task automatic write_regs(input logic [BYTE_W-1:0] id, input logic mon);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LOCAL_ID;
    cfg_data_i <= id;
    @(negedge clk_i);
    cfg_idx_i  <= REG_MONITOR;
    cfg_data_i <= CFG_DATA_W'(mon);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Stop offering, wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register setting, then a weighted mix of packets, pops, queries and unused actions.
  task automatic run_phase(input logic [BYTE_W-1:0] id, input logic mon, input int budget,
                           input int store_pct, input int pop_pct, input bit squeeze,
                           input bit overlong);
    int                goal;
    int                pick;
    int                len;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] id_byte;
    logic [BYTE_W-1:0] qtype;
    write_regs(id, mon);
    goal = items_sent + budget;
    if (squeeze) begin
      // The receiver holds off while pops keep coming, so the block backs up.
      hold_req = 1'b1;
      repeat (4) pop_head();
    end
    if (overlong) send_packet(PACKET_BYTES + 3, 8'h02, id);
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < store_pct) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, ID_BYTE);
          1:       len = PACKET_BYTES;
          default: len = $urandom_range(ID_BYTE + 1, 8);
        endcase
        frame_type = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                 : BYTE_W'($urandom_range(1, 3));
        id_byte = ($urandom_range(0, 3) != 0) ? id : BYTE_W'($urandom_range(0, 255));
        send_packet(len, frame_type, id_byte);
      end else if (pick < store_pct + pop_pct) begin
        pop_head();
      end else if (pick < store_pct + pop_pct + 3) begin
        send_item(ACT_NONE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  BYTE_W'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0:       qtype = ANY_TYPE;
          1:       qtype = BYTE_W'($urandom_range(0, 255));
          default: qtype = BYTE_W'($urandom_range(1, 3));
        endcase
        ask_ready(qtype);
      end
    end
    drain();
  endtask

  // Receiver stalls: free, light and heavy stretches, plus one long hold on request.
  initial begin : receiver_flow
    flow_mode_e mode;
    int         span;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        mode = FLOW_HOLD;
        span = HOLD_CYCLES;
      end else begin
        mode = flow_mode_e'($urandom_range(0, 2));
        span = $urandom_range(8, 60);
      end
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          FLOW_FREE:  out_stall_i <= 1'b0;
          FLOW_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          FLOW_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_RX;
    rx_byte_i    = '0;
    rx_last_i    = 1'b0;
    query_type_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_LOCAL_ID;
    cfg_data_i   = '0;
    items_sent   = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_regs(8'h00, 1'b0);

    // Empty ring: the query says not ready and a pop reports the ring empty.
    ask_ready(ANY_TYPE);
    pop_head();
    // The unused action is ignored.
    send_item(ACT_NONE, 8'hFF, 1'b1, 8'hFF);
    // A full-header packet whose station byte matches the id.
    send_rx(8'hFF, 1'b0);
    send_rx(8'h00, 1'b0);
    send_rx(8'hAA, 1'b0);
    send_rx(8'h55, 1'b0);
    send_rx(8'h00, 1'b1);
    // A packet too short to reach the station byte is judged by the stale byte.
    send_rx(8'h3C, 1'b0);
    send_rx(8'hC3, 1'b1);
    // A foreign station byte is filtered out.
    send_packet(ID_BYTE + 1, 8'h11, 8'h7F);
    // Queries for the head frame type, another type and any type.
    ask_ready(8'hFF);
    ask_ready(8'h01);
    ask_ready(ANY_TYPE);
    // Two pops empty the ring again; the third finds it empty.
    repeat (3) pop_head();
    drain();

    // Filling phase: the ring goes full, packets are dropped or filtered while full.
    run_phase(8'hFF, 1'b0, 100, 90, 2, 1'b0, 1'b0);
    run_phase(BYTE_W'($urandom_range(0, 255)), 1'b1, 50, 55, 20, 1'b0, 1'b0);
    run_phase(BYTE_W'($urandom_range(0, 255)), 1'b0, 50, 35, 45, 1'b1, 1'b0);
    run_phase(8'h00, 1'b0, 70, 50, 25, 1'b0, 1'b1);
    run_phase(8'hA5, 1'b1, 40, 75, 10, 1'b0, 1'b0);

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/frpr_pkg.sv
rtl/frpr_ram.sv
rtl/frpr_ctrl.sv
rtl/frpr_datapath.sv
rtl/filtered_packet_receive_ring_core.sv
test/ring_checker.sv
test/testbench.sv
